@@ hdl/rpf_pkg.sv @@
// Shared types, constants and register codes of the pixel format mapper.
`timescale 1ns / 1ps

package rpf_pkg;

	// Palette size and port widths
	localparam int PALETTE_ENTRIES = 4;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 32;
	localparam int CHAN_W          = 8;
	localparam int WORD_W          = 32;
	localparam int COLOR_W         = 24;
	localparam int CODE_W          = 8;
	localparam int FMT_W           = 4;
	localparam int COUNT_W         = 3;
	localparam int SQ_W            = 16;
	localparam int DIST_W          = 18;
	localparam int ACC_W           = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAL0   = 4'd2;

	// Rec.709 luma weights in Q0.16, summing to 65536
	localparam logic [15:0] LUMA_KR = 16'd13933;
	localparam logic [15:0] LUMA_KG = 16'd46871;
	localparam logic [15:0] LUMA_KB = 16'd4732;

	// Half of full scale (255 * 32768) and the rounding offset for grey
	localparam logic [ACC_W-1:0] MONO_THRESH = 24'd8355840;
	localparam logic [ACC_W-1:0] GREY_ROUND  = 24'd32768;

	localparam logic [CHAN_W-1:0]  CHAN_MASK6 = 8'hFC;
	localparam logic [COLOR_W-1:0] WHITE_RGB  = 24'hFFFFFF;

	// Reset values of the configuration registers
	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd0;
	localparam logic [WORD_W-1:0]  PAL_RESET   = 32'd0;

	typedef enum logic [FMT_W-1:0] {
		FMT_MONO     = 4'd0,
		FMT_GREY8    = 4'd1,
		FMT_INDEXED  = 4'd2,
		FMT_PLANAR   = 4'd3,
		FMT_RGB444   = 4'd4,
		FMT_RGB565   = 4'd5,
		FMT_RGB666   = 4'd6,
		FMT_RGB888   = 4'd7,
		FMT_RGBA8888 = 4'd8
	} fmt_t;

	// Load enables of the pipeline registers
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

@@ hdl/rpf_pix_in_if.sv @@
// Input pixel channel: valid/ready handshake with one RGBA word.
`timescale 1ns / 1ps

interface rpf_pix_in_if;
	logic                       valid;
	logic                       ready;
	logic [rpf_pkg::CHAN_W-1:0] red;
	logic [rpf_pkg::CHAN_W-1:0] green;
	logic [rpf_pkg::CHAN_W-1:0] blue;
	logic [rpf_pkg::CHAN_W-1:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

@@ hdl/rpf_pix_out_if.sv @@
// Output pixel channel: valid/ready handshake with one packed pixel word.
`timescale 1ns / 1ps

interface rpf_pix_out_if;
	logic                       valid;
	logic                       ready;
	logic [rpf_pkg::WORD_W-1:0] pixel_word;

	modport source (output valid, output pixel_word, input ready);
	modport sink (input valid, input pixel_word, output ready);
endinterface

@@ hdl/rpf_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
`timescale 1ns / 1ps

interface rpf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rpf_pkg::CFG_IDX_W-1:0]  index;
	logic [rpf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/rpf_cfg_regs.sv @@
// Configuration register file: format, palette count and palette entries.
`timescale 1ns / 1ps

module rpf_cfg_regs #(
	parameter int PALETTE_ENTRIES = rpf_pkg::PALETTE_ENTRIES
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          wr_en,
	input  logic [rpf_pkg::CFG_IDX_W-1:0]                 wr_index,
	input  logic [rpf_pkg::CFG_DATA_W-1:0]                wr_data,
	output logic [rpf_pkg::FMT_W-1:0]                     format,
	output logic [rpf_pkg::COUNT_W-1:0]                   count,
	output logic [PALETTE_ENTRIES-1:0][rpf_pkg::WORD_W-1:0] palette
);

	logic [rpf_pkg::FMT_W-1:0]                       format_q;
	logic [rpf_pkg::COUNT_W-1:0]                     count_q;
	logic [PALETTE_ENTRIES-1:0][rpf_pkg::WORD_W-1:0] palette_q;

	// Write format and count; ignore indexes past the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= rpf_pkg::FMT_RGB888;
			count_q  <= rpf_pkg::COUNT_RESET;
		end else if (wr_en) begin
			if (wr_index == rpf_pkg::REG_FORMAT) begin
				format_q <= wr_data[rpf_pkg::FMT_W-1:0];
			end
			if (wr_index == rpf_pkg::REG_COUNT) begin
				count_q <= wr_data[rpf_pkg::COUNT_W-1:0];
			end
		end
	end

	// One register per palette entry, decoded at its own index
	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_pal
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				palette_q[k] <= rpf_pkg::PAL_RESET;
			end else if (wr_en &&
				wr_index == rpf_pkg::REG_PAL0 + rpf_pkg::CFG_IDX_W'(k)) begin
				palette_q[k] <= wr_data;
			end
		end
	end

	assign format  = format_q;
	assign count   = count_q;
	assign palette = palette_q;

endmodule

@@ hdl/rpf_luma.sv @@
// Luma datapath: weighted channel products in stage 1, their sum in stage 2.
`timescale 1ns / 1ps

module rpf_luma (
	input  logic                          clk,
	input  rpf_pkg::pipe_ctl_t            ctl,
	input  logic [rpf_pkg::CHAN_W-1:0]    red,
	input  logic [rpf_pkg::CHAN_W-1:0]    green,
	input  logic [rpf_pkg::CHAN_W-1:0]    blue,
	output logic [rpf_pkg::ACC_W-1:0]     acc_s2
);

	logic [rpf_pkg::ACC_W-1:0] prod_r;
	logic [rpf_pkg::ACC_W-1:0] prod_g;
	logic [rpf_pkg::ACC_W-1:0] prod_b;
	logic [rpf_pkg::ACC_W-1:0] prod_r_s1;
	logic [rpf_pkg::ACC_W-1:0] prod_g_s1;
	logic [rpf_pkg::ACC_W-1:0] prod_b_s1;

	// Weight each channel; every product fits in 24 bits
	assign prod_r = rpf_pkg::ACC_W'(rpf_pkg::LUMA_KR) * rpf_pkg::ACC_W'(red);
	assign prod_g = rpf_pkg::ACC_W'(rpf_pkg::LUMA_KG) * rpf_pkg::ACC_W'(green);
	assign prod_b = rpf_pkg::ACC_W'(rpf_pkg::LUMA_KB) * rpf_pkg::ACC_W'(blue);

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_r_s1 <= prod_r;
			prod_g_s1 <= prod_g;
			prod_b_s1 <= prod_b;
		end
	end

	// Sum to 255 * luma in Q8.16; the weights sum to one, so no overflow
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			acc_s2 <= prod_r_s1 + prod_g_s1 + prod_b_s1;
		end
	end

endmodule

@@ hdl/rpf_dist.sv @@
// Distance lanes: squared channel differences in stage 1, lane sums in stage 2.
`timescale 1ns / 1ps

module rpf_dist #(
	parameter int LANES = rpf_pkg::PALETTE_ENTRIES + 1
) (
	input  logic                                        clk,
	input  rpf_pkg::pipe_ctl_t                          ctl,
	input  logic [rpf_pkg::CHAN_W-1:0]                  red,
	input  logic [rpf_pkg::CHAN_W-1:0]                  green,
	input  logic [rpf_pkg::CHAN_W-1:0]                  blue,
	input  logic [LANES-1:0][rpf_pkg::COLOR_W-1:0]      colors,
	output logic [LANES-1:0][rpf_pkg::DIST_W-1:0]       dist_s2
);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic signed [rpf_pkg::CHAN_W:0]     dr;
		logic signed [rpf_pkg::CHAN_W:0]     dg;
		logic signed [rpf_pkg::CHAN_W:0]     db;
		logic signed [2*rpf_pkg::CHAN_W+1:0] sq_r;
		logic signed [2*rpf_pkg::CHAN_W+1:0] sq_g;
		logic signed [2*rpf_pkg::CHAN_W+1:0] sq_b;
		logic [rpf_pkg::SQ_W-1:0]            sq_r_s1;
		logic [rpf_pkg::SQ_W-1:0]            sq_g_s1;
		logic [rpf_pkg::SQ_W-1:0]            sq_b_s1;

		// Take signed channel differences against this lane's color
		assign dr = $signed({1'b0, red})   - $signed({1'b0, colors[k][23:16]});
		assign dg = $signed({1'b0, green}) - $signed({1'b0, colors[k][15:8]});
		assign db = $signed({1'b0, blue})  - $signed({1'b0, colors[k][7:0]});

		// Square; the result is at most 255^2 and fits in 16 bits
		assign sq_r = dr * dr;
		assign sq_g = dg * dg;
		assign sq_b = db * db;

		always_ff @(posedge clk) begin
			if (ctl.en_s1) begin
				sq_r_s1 <= sq_r[rpf_pkg::SQ_W-1:0];
				sq_g_s1 <= sq_g[rpf_pkg::SQ_W-1:0];
				sq_b_s1 <= sq_b[rpf_pkg::SQ_W-1:0];
			end
		end

		// Add the three squares
		always_ff @(posedge clk) begin
			if (ctl.en_s2) begin
				dist_s2[k] <= rpf_pkg::DIST_W'(sq_r_s1) + rpf_pkg::DIST_W'(sq_g_s1) +
					rpf_pkg::DIST_W'(sq_b_s1);
			end
		end
	end

endmodule

@@ hdl/rpf_format.sv @@
// Final stage logic: nearest-color search and packing of the pixel word.
`timescale 1ns / 1ps

module rpf_format #(
	parameter int PALETTE_ENTRIES = rpf_pkg::PALETTE_ENTRIES
) (
	input  logic [rpf_pkg::FMT_W-1:0]                         format,
	input  logic [rpf_pkg::COUNT_W-1:0]                       count,
	input  logic [PALETTE_ENTRIES-1:0][rpf_pkg::CODE_W-1:0]   codes,
	input  logic [PALETTE_ENTRIES:0][rpf_pkg::DIST_W-1:0]     lane_dist,
	input  logic [rpf_pkg::ACC_W-1:0]                         acc,
	input  logic [rpf_pkg::CHAN_W-1:0]                        red,
	input  logic [rpf_pkg::CHAN_W-1:0]                        green,
	input  logic [rpf_pkg::CHAN_W-1:0]                        blue,
	input  logic [rpf_pkg::CHAN_W-1:0]                        alpha,
	output logic [rpf_pkg::WORD_W-1:0]                        pixel_word
);

	logic [rpf_pkg::COUNT_W-1:0] used;
	logic                        planar;
	logic [rpf_pkg::ACC_W-1:0]   grey_sum;
	logic [rpf_pkg::WORD_W-1:0]  near_word;

	// Clamp the entry count to the palette size
	assign used = (count > rpf_pkg::COUNT_W'(PALETTE_ENTRIES)) ?
		rpf_pkg::COUNT_W'(PALETTE_ENTRIES) : count;
	assign planar = (format == rpf_pkg::FMT_PLANAR);

	// Round half up; the sum stays below 2^24
	assign grey_sum = acc + rpf_pkg::GREY_ROUND;

	// Scan entries in order; only a strictly nearer entry replaces the best.
	// Planar starts from white holding the best, indexed from nothing.
	always_comb begin
		logic                        have;
		logic [rpf_pkg::DIST_W-1:0]  best;
		have      = planar;
		best      = lane_dist[PALETTE_ENTRIES];
		near_word = '0;
		for (int k = 0; k < PALETTE_ENTRIES; k++) begin
			if (rpf_pkg::COUNT_W'(k) < used && (!have || lane_dist[k] < best)) begin
				have = 1'b1;
				best = lane_dist[k];
				if (planar) begin
					near_word = rpf_pkg::WORD_W'(1) << k;
				end else begin
					near_word = rpf_pkg::WORD_W'(codes[k]);
				end
			end
		end
	end

	// Pack by format; unused codes give zero
	always_comb begin
		unique case (rpf_pkg::fmt_t'(format))
			rpf_pkg::FMT_MONO: begin
				pixel_word = rpf_pkg::WORD_W'(acc >= rpf_pkg::MONO_THRESH);
			end
			rpf_pkg::FMT_GREY8: begin
				pixel_word = rpf_pkg::WORD_W'(grey_sum[rpf_pkg::ACC_W-1:16]);
			end
			rpf_pkg::FMT_INDEXED, rpf_pkg::FMT_PLANAR: begin
				pixel_word = near_word;
			end
			rpf_pkg::FMT_RGB444: begin
				pixel_word = {20'd0, red[7:4], green[7:4], blue[7:4]};
			end
			rpf_pkg::FMT_RGB565: begin
				pixel_word = {16'd0, red[7:3], green[7:2], blue[7:3]};
			end
			rpf_pkg::FMT_RGB666: begin
				pixel_word = {8'd0, red & rpf_pkg::CHAN_MASK6, green & rpf_pkg::CHAN_MASK6,
					blue & rpf_pkg::CHAN_MASK6};
			end
			rpf_pkg::FMT_RGB888: begin
				pixel_word = {8'd0, red, green, blue};
			end
			rpf_pkg::FMT_RGBA8888: begin
				pixel_word = {red, green, blue, alpha};
			end
			default: begin
				pixel_word = '0;
			end
		endcase
	end

endmodule

@@ hdl/rgb_to_pixel_format_mapper_top.sv @@
// Top level of the RGB to display pixel format mapper: pipeline control and wiring.
// An accepted input word passes the stage 1, stage 2 and output registers in turn.
// Throughput: one word per cycle; stages hold on output stall and fill bubbles.
// Every path is fixed length: products, then sums, then palette search and packing.
// Reset clears all stage valid bits and sets format to rgb888, count 0, palette 0.
// The configuration port is always ready; write it only while the pipeline is empty.
`timescale 1ns / 1ps

module rgb_to_pixel_format_mapper_top #(
	parameter int PALETTE_ENTRIES = rpf_pkg::PALETTE_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	rpf_pix_in_if.sink    pix_in,
	rpf_pix_out_if.source pix_out,
	rpf_cfg_if.sink       cfg
);

	logic [rpf_pkg::FMT_W-1:0]                       format;
	logic [rpf_pkg::COUNT_W-1:0]                     count;
	logic [PALETTE_ENTRIES-1:0][rpf_pkg::WORD_W-1:0] palette;
	logic [PALETTE_ENTRIES:0][rpf_pkg::COLOR_W-1:0]  colors;
	logic [PALETTE_ENTRIES-1:0][rpf_pkg::CODE_W-1:0] codes;
	logic [PALETTE_ENTRIES:0][rpf_pkg::DIST_W-1:0]   dist_s2;
	logic [rpf_pkg::ACC_W-1:0]                       acc_s2;
	logic [rpf_pkg::WORD_W-1:0]                      word_next;
	rpf_pkg::pipe_ctl_t                              ctl;

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       ready_s1;
	logic                       ready_s2;
	logic                       ready_s3;
	logic [rpf_pkg::CHAN_W-1:0] red_s1;
	logic [rpf_pkg::CHAN_W-1:0] green_s1;
	logic [rpf_pkg::CHAN_W-1:0] blue_s1;
	logic [rpf_pkg::CHAN_W-1:0] alpha_s1;
	logic [rpf_pkg::CHAN_W-1:0] red_s2;
	logic [rpf_pkg::CHAN_W-1:0] green_s2;
	logic [rpf_pkg::CHAN_W-1:0] blue_s2;
	logic [rpf_pkg::CHAN_W-1:0] alpha_s2;
	logic [rpf_pkg::WORD_W-1:0] word_s3;

	// Configuration registers
	assign cfg.ready = 1'b1;

	rpf_cfg_regs #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.format   (format),
		.count    (count),
		.palette  (palette)
	);

	// Split palette entries into colors and codes; white rides as the last lane
	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_split
		assign colors[k] = palette[k][rpf_pkg::COLOR_W-1:0];
		assign codes[k]  = palette[k][rpf_pkg::WORD_W-1:rpf_pkg::COLOR_W];
	end
	assign colors[PALETTE_ENTRIES] = rpf_pkg::WHITE_RGB;

	// Advance a stage when it is empty or its successor advances
	assign ready_s3  = !valid_s3 || pix_out.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign ctl.en_s1 = ready_s1;
	assign ctl.en_s2 = ready_s2;
	assign ctl.en_s3 = ready_s3;
	assign pix_in.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Carry the channels alongside the arithmetic
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			red_s1   <= pix_in.red;
			green_s1 <= pix_in.green;
			blue_s1  <= pix_in.blue;
			alpha_s1 <= pix_in.alpha;
		end
		if (ctl.en_s2) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	rpf_luma u_luma (
		.clk    (clk),
		.ctl    (ctl),
		.red    (pix_in.red),
		.green  (pix_in.green),
		.blue   (pix_in.blue),
		.acc_s2 (acc_s2)
	);

	rpf_dist #(
		.LANES(PALETTE_ENTRIES + 1)
	) u_dist (
		.clk     (clk),
		.ctl     (ctl),
		.red     (pix_in.red),
		.green   (pix_in.green),
		.blue    (pix_in.blue),
		.colors  (colors),
		.dist_s2 (dist_s2)
	);

	rpf_format #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_format (
		.format     (format),
		.count      (count),
		.codes      (codes),
		.lane_dist  (dist_s2),
		.acc        (acc_s2),
		.red        (red_s2),
		.green      (green_s2),
		.blue       (blue_s2),
		.alpha      (alpha_s2),
		.pixel_word (word_next)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			word_s3 <= word_next;
		end
	end

	assign pix_out.valid      = valid_s3;
	assign pix_out.pixel_word = word_s3;

endmodule

@@ hdl/rpf_checker.sv @@
// Port-level checker of the pixel format mapper and its bind to the top level.
`timescale 1ns / 1ps

module rpf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rpf_pkg::WORD_W-1:0] pixel_word
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// Never deliver a word that was not accepted; never hold more than three
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("output word without a pending input word");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more than three words in flight");

	// With the output draining, an accepted word reaches the output once it has passed stages 1 and 2
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc, 3) && $past(out_ready, 2) && $past(out_ready, 1) |-> out_valid)
		else $error("accepted word missing after three cycles");

	// A draining output never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_word))
		else $error("stalled output word changed");

endmodule

bind rgb_to_pixel_format_mapper_top rpf_checker u_rpf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.pixel_word (pix_out.pixel_word)
);
